### rtl/core/spwar_pkg.sv
// ----------------------------------------------------------------------------
// spwar_pkg
// Shared widths and register codes for the axis radius point selector.
// ----------------------------------------------------------------------------
`default_nettype none

package spwar_pkg;

    localparam int COORD_BITS = 32;
    localparam int INDEX_BITS = 24;
    localparam int DIST_BITS  = COORD_BITS - 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;            // point minus origin
    localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;    // r * a
    localparam int CROSS_BITS = PROD_BITS + 1;             // cross product term
    localparam int MAG_BITS   = CROSS_BITS - 1;            // its magnitude
    localparam int LO_BITS    = (MAG_BITS + 1) / 2;
    localparam int HI_BITS    = MAG_BITS - LO_BITS;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int NUM_BITS   = SQ_BITS + 2;               // sum of three squares
    localparam int DEN_BITS   = 2 * COORD_BITS;            // |a|^2
    localparam int ADDR_BITS  = 3;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_RADIUS   = 3'd6
    } t_reg_addr;

endpackage

`default_nettype wire

### rtl/core/spwar_sqrt.sv
// ----------------------------------------------------------------------------
// spwar_sqrt
// Pipelined bit-serial search for the largest L with L*L*den <= num, one
// result bit per stage. Keeps residual num - L^2*den and Y = L*den so each
// stage needs only shifts, wide adds and subtracts and one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module spwar_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [spwar_pkg::NUM_BITS-1:0] i_num,
    input  wire logic [spwar_pkg::DEN_BITS-1:0] i_den,
    input  wire logic [spwar_pkg::INDEX_BITS-1:0] i_tag,
    output logic                                o_valid,
    output logic [spwar_pkg::DIST_BITS-1:0]     o_dist,
    output logic [spwar_pkg::INDEX_BITS-1:0]    o_tag
);
    import spwar_pkg::*;

    logic                  r_v   [0:DIST_BITS];
    logic [NUM_BITS-1:0]   r_res [0:DIST_BITS];
    logic [NUM_BITS-1:0]   r_y   [0:DIST_BITS];
    logic [NUM_BITS-1:0]   r_den [0:DIST_BITS];
    logic [DIST_BITS-1:0]  r_l   [0:DIST_BITS];
    logic [INDEX_BITS-1:0] r_tag [0:DIST_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_res[0] <= i_num;
            r_y[0]   <= '0;
            r_den[0] <= NUM_BITS'(i_den);
            r_l[0]   <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < DIST_BITS; k++) begin : g_step
        localparam int B = DIST_BITS - 1 - k;
        logic [NUM_BITS-1:0] w_cand;
        logic                w_take;

        assign w_cand = (r_y[k] << (B + 1)) + (r_den[k] << (2 * B));
        assign w_take = (w_cand <= r_res[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_res[k+1] <= w_take ? r_res[k] - w_cand : r_res[k];
                r_y[k+1]   <= w_take ? r_y[k] + (r_den[k] << B) : r_y[k];
                r_l[k+1]   <= r_l[k] | (w_take ? DIST_BITS'(1) << B : '0);
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[DIST_BITS];
    assign o_dist  = r_l[DIST_BITS];
    assign o_tag   = r_tag[DIST_BITS];

endmodule

`default_nettype wire

### rtl/core/select_points_within_axis_radius_top.sv
// ----------------------------------------------------------------------------
// select_points_within_axis_radius_top
// Selects points whose perpendicular distance to a configured axis (or, for a
// zero axis, distance to the origin) is strictly below a configured radius.
//
// Input channel: i_in_valid / o_in_stall carry one point word (x, y, z in
// signed Q16.16 and an index). Output channel: o_out_valid / i_out_stall
// carry the index and the unsigned Q15.16 distance of each selected point;
// points outside the radius give no word. Configuration: i_cfg_we writes the
// register at i_cfg_addr with i_cfg_wdata; the user must write only while
// the block is idle, as the block does not enforce it. One point is accepted
// per cycle while o_in_stall is low. A point passes 40 registers: 7 front
// stages (difference, products, cross product, magnitude, split squaring,
// squares, sum), the square-root input register with 31 stages after it
// (one distance bit each) and the output register. Synchronous active-low
// reset clears all valid bits and loads the axis (0, 0, 1.0), origin 0 and
// radius 0. A stall on the output while a word is presented freezes the
// whole pipeline in place; o_in_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module select_points_within_axis_radius_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [spwar_pkg::ADDR_BITS-1:0]     i_cfg_addr,
    input  wire logic [spwar_pkg::COORD_BITS-1:0]    i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [spwar_pkg::COORD_BITS-1:0] i_point_x,
    input  wire logic signed [spwar_pkg::COORD_BITS-1:0] i_point_y,
    input  wire logic signed [spwar_pkg::COORD_BITS-1:0] i_point_z,
    input  wire logic [spwar_pkg::INDEX_BITS-1:0]    i_point_index,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [spwar_pkg::INDEX_BITS-1:0]         o_selected_index,
    output logic [spwar_pkg::DIST_BITS-1:0]          o_axis_distance
);
    import spwar_pkg::*;

    logic signed [COORD_BITS-1:0] r_org [0:2];
    logic signed [COORD_BITS-1:0] r_ax  [0:2];
    logic [DIST_BITS-1:0]         r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_ax[0]  <= '0;
            r_ax[1]  <= '0;
            r_ax[2]  <= COORD_BITS'(65536);
            r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ORIGIN_X: r_org[0] <= i_cfg_wdata;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_wdata;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_wdata;
                REG_AXIS_X:   r_ax[0]  <= i_cfg_wdata;
                REG_AXIS_Y:   r_ax[1]  <= i_cfg_wdata;
                REG_AXIS_Z:   r_ax[2]  <= i_cfg_wdata;
                REG_RADIUS:   r_radius <= i_cfg_wdata[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic w_zero_axis;

    assign w_en        = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign w_zero_axis = (r_ax[0] == '0) && (r_ax[1] == '0) && (r_ax[2] == '0);

    // stage valids 1..7
    logic [7:1] r_v;
    logic [INDEX_BITS-1:0] r_idx [1:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[6:1], i_in_valid};
        end
        if (w_en) begin
            r_idx[1] <= i_point_index;
            for (int s = 2; s <= 7; s++) begin
                r_idx[s] <= r_idx[s-1];
            end
        end
    end

    // stage 1: r = p - origin
    logic signed [DIFF_BITS-1:0] r_r1 [0:2];
    // stage 2: cross product terms and axis squares
    logic signed [PROD_BITS-1:0] r_p2 [0:5];
    logic signed [DIFF_BITS-1:0] r_r2 [0:2];
    logic [DEN_BITS-1:0]         r_a2 [0:2];
    // stage 3: cross product, denominator
    logic signed [CROSS_BITS-1:0] r_c3 [0:2];
    logic [DEN_BITS-1:0]          r_den3;
    // stage 4: magnitudes
    logic [MAG_BITS-1:0] r_m4 [0:2];
    logic [DEN_BITS-1:0] r_den4;
    // stage 5: partial products of the squares
    logic [2*HI_BITS-1:0]       r_hh5 [0:2];
    logic [HI_BITS+LO_BITS-1:0] r_hl5 [0:2];
    logic [2*LO_BITS-1:0]       r_ll5 [0:2];
    logic [DEN_BITS-1:0]        r_den5;
    // stage 6: squares
    logic [SQ_BITS-1:0]  r_sq6 [0:2];
    logic [DEN_BITS-1:0] r_den6;
    // stage 7: numerator
    logic [NUM_BITS-1:0] r_num7;
    logic [DEN_BITS-1:0] r_den7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1[0] <= DIFF_BITS'(i_point_x) - DIFF_BITS'(r_org[0]);
            r_r1[1] <= DIFF_BITS'(i_point_y) - DIFF_BITS'(r_org[1]);
            r_r1[2] <= DIFF_BITS'(i_point_z) - DIFF_BITS'(r_org[2]);

            r_p2[0] <= r_r1[1] * r_ax[2];
            r_p2[1] <= r_r1[2] * r_ax[1];
            r_p2[2] <= r_r1[2] * r_ax[0];
            r_p2[3] <= r_r1[0] * r_ax[2];
            r_p2[4] <= r_r1[0] * r_ax[1];
            r_p2[5] <= r_r1[1] * r_ax[0];
            for (int i = 0; i < 3; i++) begin
                r_r2[i] <= r_r1[i];
                r_a2[i] <= r_ax[i] * r_ax[i];
            end

            if (w_zero_axis) begin
                for (int i = 0; i < 3; i++) begin
                    r_c3[i] <= CROSS_BITS'(r_r2[i]);
                end
                r_den3 <= DEN_BITS'(1);
            end else begin
                r_c3[0] <= CROSS_BITS'(r_p2[0]) - CROSS_BITS'(r_p2[1]);
                r_c3[1] <= CROSS_BITS'(r_p2[2]) - CROSS_BITS'(r_p2[3]);
                r_c3[2] <= CROSS_BITS'(r_p2[4]) - CROSS_BITS'(r_p2[5]);
                r_den3  <= r_a2[0] + r_a2[1] + r_a2[2];
            end

            for (int i = 0; i < 3; i++) begin
                r_m4[i] <= r_c3[i][CROSS_BITS-1] ? MAG_BITS'(-r_c3[i])
                                                 : MAG_BITS'(r_c3[i]);
            end
            r_den4 <= r_den3;

            for (int i = 0; i < 3; i++) begin
                r_hh5[i] <= r_m4[i][MAG_BITS-1:LO_BITS] * r_m4[i][MAG_BITS-1:LO_BITS];
                r_hl5[i] <= r_m4[i][MAG_BITS-1:LO_BITS] * r_m4[i][LO_BITS-1:0];
                r_ll5[i] <= r_m4[i][LO_BITS-1:0] * r_m4[i][LO_BITS-1:0];
            end
            r_den5 <= r_den4;

            for (int i = 0; i < 3; i++) begin
                r_sq6[i] <= (SQ_BITS'(r_hh5[i]) << (2 * LO_BITS))
                          + (SQ_BITS'(r_hl5[i]) << (LO_BITS + 1))
                          + SQ_BITS'(r_ll5[i]);
            end
            r_den6 <= r_den5;

            r_num7 <= NUM_BITS'(r_sq6[0]) + NUM_BITS'(r_sq6[1]) + NUM_BITS'(r_sq6[2]);
            r_den7 <= r_den6;
        end
    end

    logic                  w_sq_valid;
    logic [DIST_BITS-1:0]  w_sq_dist;
    logic [INDEX_BITS-1:0] w_sq_tag;

    spwar_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v[7]),
        .i_num   (r_num7),
        .i_den   (r_den7),
        .i_tag   (r_idx[7]),
        .o_valid (w_sq_valid),
        .o_dist  (w_sq_dist),
        .o_tag   (w_sq_tag)
    );

    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_idx;
    logic [DIST_BITS-1:0]  r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sq_valid && (w_sq_dist < r_radius);
        end
        if (w_en) begin
            r_out_idx  <= w_sq_tag;
            r_out_dist <= w_sq_dist;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_idx;
    assign o_axis_distance  = r_out_dist;

endmodule

`default_nettype wire

### tb/tb_select_points_within_axis_radius_top.sv
// ----------------------------------------------------------------------------
// tb_select_points_within_axis_radius_top
// Self-checking bench for the axis radius point selector.
//
// Points are streamed in bursts under several register settings: the reset
// axis, a zero axis, extreme origin and axis values, full random values and
// the smallest and zero radius. A scoreboard works out each point's
// perpendicular distance with wide integer arithmetic, queues the words that
// should be selected and checks the output words in order while the output
// side stalls at random in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_select_points_within_axis_radius_top;
    import spwar_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PIPE_LATENCY = 40;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_POINTS = 270;
    localparam logic [ADDR_BITS-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [INDEX_BITS-1:0] idx;
        logic [DIST_BITS-1:0]  distance;
    } t_selection;

    class cylinder_scoreboard;
        logic signed [COORD_BITS-1:0] org_x, org_y, org_z, ax_x, ax_y, ax_z;
        logic [DIST_BITS-1:0]         radius;
        t_selection                   pending[$];
        int                           mismatches;
        int                           points_seen;
        int                           selections_seen;

        function void clear_regs();
            org_x = '0; org_y = '0; org_z = '0;
            ax_x = '0; ax_y = '0; ax_z = 32'sd65536;
            radius = '0;
        endfunction

        function void write_reg(logic [ADDR_BITS-1:0] addr, logic [COORD_BITS-1:0] data);
            case (addr)
                REG_ORIGIN_X: org_x = data;
                REG_ORIGIN_Y: org_y = data;
                REG_ORIGIN_Z: org_z = data;
                REG_AXIS_X:   ax_x = data;
                REG_AXIS_Y:   ax_y = data;
                REG_AXIS_Z:   ax_z = data;
                REG_RADIUS:   radius = data[DIST_BITS-1:0];
                default: ;
            endcase
        endfunction

        // largest d with d*d*|a|^2 <= |r x a|^2 (|r|^2 for a zero axis), saturating at 31 bits
        function logic [DIST_BITS-1:0] axis_dist(logic signed [COORD_BITS-1:0] px,
                                                 logic signed [COORD_BITS-1:0] py,
                                                 logic signed [COORD_BITS-1:0] pz);
            logic signed [255:0] rx, ry, rz, ax, ay, az, cx, cy, cz, sq_num, sq_den;
            logic [255:0] tw;
            logic [DIST_BITS-1:0] d, t;
            rx = px; rx = rx - org_x;
            ry = py; ry = ry - org_y;
            rz = pz; rz = rz - org_z;
            ax = ax_x; ay = ax_y; az = ax_z;
            sq_den = ax * ax + ay * ay + az * az;
            if (sq_den == 0) begin
                sq_num = rx * rx + ry * ry + rz * rz;
                sq_den = 1;
            end else begin
                cx = ry * az - rz * ay;
                cy = rz * ax - rx * az;
                cz = rx * ay - ry * ax;
                sq_num = cx * cx + cy * cy + cz * cz;
            end
            d = '0;
            for (int b = DIST_BITS - 1; b >= 0; b--) begin
                t = d | (31'd1 << b);
                tw = t;
                tw = tw * tw * $unsigned(sq_den);
                if (tw <= $unsigned(sq_num)) d = t;
            end
            return d;
        endfunction

        function void note_point(logic signed [COORD_BITS-1:0] px,
                                 logic signed [COORD_BITS-1:0] py,
                                 logic signed [COORD_BITS-1:0] pz,
                                 logic [INDEX_BITS-1:0] idx);
            t_selection s;
            s.idx = idx;
            s.distance = axis_dist(px, py, pz);
            points_seen++;
            if (s.distance < radius) pending.push_back(s);
        endfunction

        function void check_word(logic [INDEX_BITS-1:0] idx,
                                 logic [DIST_BITS-1:0] distance);
            t_selection s;
            selections_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: index %0h distance %0h", idx, distance);
                return;
            end
            s = pending.pop_front();
            if (s.idx !== idx) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("index mismatch: expected %0h actual %0h", s.idx, idx);
            end
            if (s.distance !== distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance mismatch (index %0h): expected %0h actual %0h",
                             s.idx, s.distance, distance);
            end
        endfunction
    endclass

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_we;
    logic [ADDR_BITS-1:0]  i_cfg_addr;
    logic [COORD_BITS-1:0] i_cfg_wdata;
    logic                  i_in_valid, o_in_stall;
    logic signed [COORD_BITS-1:0] i_point_x, i_point_y, i_point_z;
    logic [INDEX_BITS-1:0] i_point_index;
    logic                  o_out_valid, i_out_stall;
    logic [INDEX_BITS-1:0] o_selected_index;
    logic [DIST_BITS-1:0]  o_axis_distance;

    cylinder_scoreboard sb = new();
    bit rx_stall_en;
    int stall_run;
    bit stall_now;
    int cycles;

    select_points_within_axis_radius_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!rx_stall_en) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_now = ($urandom_range(0, 2) == 0);
                stall_run = $urandom_range(1, 12);
            end
            stall_run--;
            i_out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_selected_index, o_axis_distance);
    end

    task automatic cfg_write(logic [ADDR_BITS-1:0] addr, logic [COORD_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(addr, data);
    endtask

    task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                              logic [COORD_BITS-1:0] pz, logic [INDEX_BITS-1:0] idx);
        i_in_valid <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        i_point_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(px, py, pz, idx);
    endtask

    task automatic drain();
        rx_stall_en = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] base);
        int sh;
        sh = $urandom_range(0, 24);
        return base + $urandom_range(0, 2 << sh) - (1 << sh);
    endfunction

    function automatic logic [COORD_BITS-1:0] corner(int k);
        case (k % 4)
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic set_phase(int p);
        logic [COORD_BITS-1:0] v[7];
        case (p)
            1: v = '{near(0), near(0), near(0), near(0), near(0), near(0),
                     $urandom_range(1 << 16, 1 << 26)};
            2: v = '{near(0), near(0), near(0), 0, 0, 0, 32'h7fff_ffff};
            3: v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
            4: v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            5: v = '{0, 0, 0, 32'h0001_0000, 0, 0, 1};
            default: v = '{near(0), near(0), near(0), 32'h7fff_ffff, 1, 32'h8000_0000, 0};
        endcase
        for (int r = 0; r < 7; r++)
            cfg_write(t_reg_addr'(r), v[r]);
        cfg_write(REG_UNUSED, $urandom);
    endtask

    initial begin
        int gap, burst;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_ORIGIN_X;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_point_index = '0;
        i_out_stall = 1'b0;
        rx_stall_en = 1'b0;
        stall_run = 0;
        cycles = 0;
        sb.clear_regs();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) set_phase(p);
            // field corners, then a point exactly at the origin
            for (int k = 0; k < 4; k++)
                send_point(corner(k), corner(k + 1), corner(k + 2), k[0] ? 24'hff_ffff : 24'h0);
            send_point(sb.org_x, sb.org_y, sb.org_z, $urandom);
            rx_stall_en = (p % 3 != 1);
            burst = 0;
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst--;
                if ($urandom_range(0, 4) == 0)
                    send_point($urandom, $urandom, $urandom, $urandom);
                else
                    send_point(near(sb.org_x), near(sb.org_y), near(sb.org_z), $urandom);
            end
            i_in_valid <= 1'b0;
            drain();
        end

        $display("%0d points sent over %0d register settings, %0d words selected",
                 sb.points_seen, NUM_PHASES, sb.selections_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words missing", sb.mismatches, sb.pending.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/spwar_pkg.sv
rtl/core/spwar_sqrt.sv
rtl/core/select_points_within_axis_radius_top.sv
tb/tb_select_points_within_axis_radius_top.sv
